>>> src/rsfrd_pkg.sv
// ----------------------------------------------------------------------------
// rsfrd_pkg
// Shared sizes, operation codes and status codes of the rank-select store.
// ----------------------------------------------------------------------------
package rsfrd_pkg;

  localparam int unsigned MAX_LEN = 4096;
  localparam int unsigned POS_W   = $clog2(MAX_LEN);
  localparam int unsigned CNT_W   = POS_W + 1;
  localparam int unsigned NODE_W  = POS_W + 1;
  localparam int unsigned NODES   = 2 * MAX_LEN;
  localparam int unsigned DEPTH_W = $clog2(POS_W + 1);
  localparam int unsigned SYM_W   = 6;
  localparam int unsigned OP_W    = 2;
  localparam int unsigned ST_W    = 2;

  typedef enum logic [OP_W-1:0] {
    OP_APPEND = 2'd0,
    OP_DELETE = 2'd1,
    OP_READ   = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK       = 2'd0,
    ST_BAD_RANK = 2'd1,
    ST_FULL     = 2'd2
  } status_e;

endpackage

>>> src/rank_select_filtered_range_delete.sv
// ----------------------------------------------------------------------------
// rank_select_filtered_range_delete
// Symbol store with alive marks and a count tree for k-th alive selection.
// ----------------------------------------------------------------------------
// One item at a time, through one shared count-tree memory port and one
// read-modify-write/compare unit. An append walks the 13 tree levels, reading
// and then writing each node on its path. A read selects its rank down the
// tree, then reads the symbol. A delete selects both ranks, then checks every
// position of the span and walks the tree once more for every position removed.
// The result sits in an output register, so the next item is taken while it
// waits. The count tree needs no clearing pass: a node whose range starts at or
// above the loaded length reads as zero, and leaf counts double as alive marks.
module rank_select_filtered_range_delete import rsfrd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [OP_W-1:0]   op_i,
  input  logic [SYM_W-1:0]  symbol_i,
  input  logic [CNT_W-1:0]  left_rank_i,
  input  logic [CNT_W-1:0]  right_rank_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [ST_W-1:0]   status_o,
  output logic [CNT_W-1:0]  removed_count_o,
  output logic [SYM_W-1:0]  read_symbol_o,
  output logic [CNT_W-1:0]  alive_total_o
);

  typedef enum logic [8:0] {
    S_IDLE     = 9'b000000001,
    S_ADJ_RD   = 9'b000000010,
    S_ADJ_WR   = 9'b000000100,
    S_SEL_RD   = 9'b000001000,
    S_SEL_CMP  = 9'b000010000,
    S_SCAN_RD  = 9'b000100000,
    S_SCAN_CHK = 9'b001000000,
    S_SYM_RD   = 9'b010000000,
    S_DONE     = 9'b100000000
  } state_e;

  localparam logic [CNT_W-1:0]   MaxLen  = CNT_W'(MAX_LEN);
  localparam logic [DEPTH_W-1:0] LastLvl = DEPTH_W'(POS_W);

  state_e               state_q, state_d;
  logic [OP_W-1:0]      op_q, op_d;
  logic [SYM_W-1:0]     sym_q, sym_d;
  logic [CNT_W-1:0]     rr_q, rr_d;
  logic [CNT_W-1:0]     k_q, k_d;
  logic [NODE_W-1:0]    node_q, node_d;
  logic [POS_W-1:0]     lo_q, lo_d;
  logic [DEPTH_W-1:0]   depth_q, depth_d;
  logic [POS_W-1:0]     pos_q, pos_d;
  logic [POS_W-1:0]     pr_q, pr_d;
  logic                 sel_rhs_q, sel_rhs_d;
  logic                 adj_up_q, adj_up_d;
  logic                 rd_hit_q, rd_hit_d;
  logic [ST_W-1:0]      st_q, st_d;
  logic [CNT_W-1:0]     removed_q, removed_d;
  logic [CNT_W-1:0]     len_q, len_d;
  logic [CNT_W-1:0]     total_q, total_d;
  logic                 out_valid_q, out_valid_d;
  logic [ST_W-1:0]      out_st_q, out_st_d;
  logic [CNT_W-1:0]     out_rem_q, out_rem_d;
  logic [SYM_W-1:0]     out_sym_q, out_sym_d;
  logic [CNT_W-1:0]     out_tot_q, out_tot_d;

  // memories
  logic [CNT_W-1:0]     tree_mem [NODES];
  logic [SYM_W-1:0]     sym_mem  [MAX_LEN];
  logic [CNT_W-1:0]     tree_rdata_q;
  logic                 tree_rvalid_q;
  logic [SYM_W-1:0]     sym_rdata_q;
  logic [NODE_W-1:0]    tree_raddr;
  logic [POS_W-1:0]     rd_lo;
  logic                 tree_we;
  logic [CNT_W-1:0]     tree_wdata;
  logic                 sym_we;

  // shared unit signals
  logic [DEPTH_W-1:0]   bit_idx;
  logic [POS_W-1:0]     path_lo;
  logic [CNT_W-1:0]     cnt;
  logic                 accept;
  logic                 bad_del, bad_rd;
  logic [POS_W-1:0]     sel_lo;

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == S_IDLE);
  assign bit_idx    = DEPTH_W'(POS_W - 1) - depth_q;
  assign path_lo    = pos_q & ~({POS_W{1'b1}} >> depth_q);
  assign cnt        = tree_rvalid_q ? tree_rdata_q : '0;
  assign sel_lo     = lo_q | (POS_W'(1) << bit_idx);

  assign bad_del = (left_rank_i == '0) || (right_rank_i == '0) || (left_rank_i > total_q) ||
                   (right_rank_i > total_q) || (left_rank_i > right_rank_i);
  assign bad_rd  = (left_rank_i == '0) || (left_rank_i > total_q);

  // tree read address and the lower bound of that node's range
  always_comb begin
    tree_raddr = node_q;
    rd_lo      = path_lo;
    case (state_q)
      S_SEL_RD: begin
        tree_raddr = {node_q[NODE_W-2:0], 1'b0};
        rd_lo      = lo_q;
      end
      S_SCAN_RD: begin
        tree_raddr = {1'b1, pos_q};
        rd_lo      = pos_q;
      end
      default: begin
        tree_raddr = node_q;
        rd_lo      = path_lo;
      end
    endcase
  end

  // count update
  assign tree_we    = (state_q == S_ADJ_WR);
  assign tree_wdata = adj_up_q ? cnt + CNT_W'(1) : ((cnt != '0) ? cnt - CNT_W'(1) : '0);
  assign sym_we     = accept && (op_i == OP_APPEND) && (len_q != MaxLen);

  always_ff @(posedge clk_i) begin
    if (tree_we) begin
      tree_mem[node_q] <= tree_wdata;
    end
    tree_rdata_q  <= tree_mem[tree_raddr];
    tree_rvalid_q <= ({1'b0, rd_lo} < len_q);
  end

  always_ff @(posedge clk_i) begin
    if (sym_we) begin
      sym_mem[len_q[POS_W-1:0]] <= symbol_i;
    end
    sym_rdata_q <= sym_mem[pos_q];
  end

  // sequencer
  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    sym_d       = sym_q;
    rr_d        = rr_q;
    k_d         = k_q;
    node_d      = node_q;
    lo_d        = lo_q;
    depth_d     = depth_q;
    pos_d       = pos_q;
    pr_d        = pr_q;
    sel_rhs_d   = sel_rhs_q;
    adj_up_d    = adj_up_q;
    rd_hit_d    = rd_hit_q;
    st_d        = st_q;
    removed_d   = removed_q;
    len_d       = len_q;
    total_d     = total_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_st_d    = out_st_q;
    out_rem_d   = out_rem_q;
    out_sym_d   = out_sym_q;
    out_tot_d   = out_tot_q;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          op_d      = op_i;
          sym_d     = symbol_i;
          rr_d      = right_rank_i;
          k_d       = left_rank_i;
          node_d    = NODE_W'(1);
          lo_d      = '0;
          depth_d   = '0;
          sel_rhs_d = 1'b0;
          rd_hit_d  = 1'b0;
          removed_d = '0;
          st_d      = ST_OK;
          case (op_i)
            OP_APPEND: begin
              if (len_q == MaxLen) begin
                st_d    = ST_FULL;
                state_d = S_DONE;
              end else begin
                pos_d    = len_q[POS_W-1:0];
                adj_up_d = 1'b1;
                state_d  = S_ADJ_RD;
              end
            end
            OP_DELETE: begin
              if (bad_del) begin
                st_d    = ST_BAD_RANK;
                state_d = S_DONE;
              end else begin
                state_d = S_SEL_RD;
              end
            end
            OP_READ: begin
              if (bad_rd) begin
                st_d    = ST_BAD_RANK;
                state_d = S_DONE;
              end else begin
                state_d = S_SEL_RD;
              end
            end
            default: begin
              st_d    = ST_BAD_RANK;
              state_d = S_DONE;
            end
          endcase
        end
      end

      S_ADJ_RD: state_d = S_ADJ_WR;

      // write back the count, then step down the path or finish
      S_ADJ_WR: begin
        if (depth_q == LastLvl) begin
          if (adj_up_q) begin
            len_d   = len_q + CNT_W'(1);
            total_d = total_q + CNT_W'(1);
            state_d = S_DONE;
          end else if (pos_q == pr_q) begin
            state_d = S_DONE;
          end else begin
            pos_d   = pos_q + POS_W'(1);
            state_d = S_SCAN_RD;
          end
        end else begin
          node_d  = {node_q[NODE_W-2:0], pos_q[bit_idx]};
          depth_d = depth_q + DEPTH_W'(1);
          state_d = S_ADJ_RD;
        end
      end

      S_SEL_RD: state_d = S_SEL_CMP;

      // compare rank with the left child's count and descend
      S_SEL_CMP: begin
        if (cnt >= k_q) begin
          node_d = {node_q[NODE_W-2:0], 1'b0};
        end else begin
          k_d    = k_q - cnt;
          node_d = {node_q[NODE_W-2:0], 1'b1};
          lo_d   = sel_lo;
        end
        depth_d = depth_q + DEPTH_W'(1);
        state_d = S_SEL_RD;
        if (depth_q == LastLvl - DEPTH_W'(1)) begin
          node_d  = NODE_W'(1);
          lo_d    = '0;
          depth_d = '0;
          k_d     = rr_q;
          if (op_q == OP_READ) begin
            pos_d    = (cnt >= k_q) ? lo_q : sel_lo;
            rd_hit_d = 1'b1;
            state_d  = S_SYM_RD;
          end else if (!sel_rhs_q) begin
            pos_d     = (cnt >= k_q) ? lo_q : sel_lo;
            sel_rhs_d = 1'b1;
          end else begin
            pr_d    = (cnt >= k_q) ? lo_q : sel_lo;
            state_d = S_SCAN_RD;
          end
        end
      end

      S_SCAN_RD: state_d = S_SCAN_CHK;

      // remove a live matching position, else move on
      S_SCAN_CHK: begin
        if ((cnt != '0) && (sym_rdata_q == sym_q)) begin
          removed_d = removed_q + CNT_W'(1);
          total_d   = total_q - CNT_W'(1);
          adj_up_d  = 1'b0;
          node_d    = NODE_W'(1);
          depth_d   = '0;
          state_d   = S_ADJ_RD;
        end else if (pos_q == pr_q) begin
          state_d = S_DONE;
        end else begin
          pos_d   = pos_q + POS_W'(1);
          state_d = S_SCAN_RD;
        end
      end

      S_SYM_RD: state_d = S_DONE;

      // hand the result to the output register
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_st_d    = st_q;
          out_rem_d   = removed_q;
          out_sym_d   = rd_hit_q ? sym_rdata_q : '0;
          out_tot_d   = total_q;
          state_d     = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      len_q       <= '0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      len_q       <= len_d;
      total_q     <= total_d;
      out_valid_q <= out_valid_d;
    end
  end

  // working and payload registers
  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    sym_q     <= sym_d;
    rr_q      <= rr_d;
    k_q       <= k_d;
    node_q    <= node_d;
    lo_q      <= lo_d;
    depth_q   <= depth_d;
    pos_q     <= pos_d;
    pr_q      <= pr_d;
    sel_rhs_q <= sel_rhs_d;
    adj_up_q  <= adj_up_d;
    rd_hit_q  <= rd_hit_d;
    st_q      <= st_d;
    removed_q <= removed_d;
    out_st_q  <= out_st_d;
    out_rem_q <= out_rem_d;
    out_sym_q <= out_sym_d;
    out_tot_q <= out_tot_d;
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = out_st_q;
  assign removed_count_o = out_rem_q;
  assign read_symbol_o   = out_sym_q;
  assign alive_total_o   = out_tot_q;

`ifndef ASSERT_OFF
  // alive symbols never outnumber loaded ones
  assert property (@(posedge clk_i) disable iff (!rst_ni) total_q <= len_q)
    else $error("alive total above loaded length");

  // the scan never runs past the right end of its span
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN_CHK) |-> (pos_q <= pr_q))
    else $error("scan past span end");

  // an error result removes nothing
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_st_q != ST_OK)) |-> (out_rem_q == '0))
    else $error("removal reported with error status");

  // an append grows the loaded length by one at most
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (len_q != $past(len_q)) |-> (len_q == $past(len_q) + CNT_W'(1)))
    else $error("loaded length jumped");
`endif

endmodule
